>>> sv/dsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared constants and types of the dense shortest path block.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VTX_BITS     = 4;
    localparam int CNT_BITS     = VTX_BITS + 1;
    localparam int WEIGHT_BITS  = 8;
    localparam int COST_BITS    = 14;
    localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int MAT_BITS     = 2 * VTX_BITS;

    localparam logic [COST_BITS-1:0] INF_COST = COST_BITS'(9999);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_UNREACH = 2'd2;

    // One word of the per-vertex working store
    typedef struct packed {
        logic [COST_BITS-1:0] cost;
        logic                 done;
        logic [VTX_BITS-1:0]  pred;
    } t_node;

endpackage
`default_nettype wire

>>> sv/dsp_wstore.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_wstore
// Weight matrix memory with a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module dsp_wstore (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [dsp_pkg::MAT_BITS-1:0]     i_wr_addr,
    input  wire logic [dsp_pkg::WEIGHT_BITS-1:0]  i_wr_data,
    input  wire logic [dsp_pkg::MAT_BITS-1:0]     i_rd_addr,
    output logic      [dsp_pkg::WEIGHT_BITS-1:0]  o_rd_data,
    output logic                                  o_busy
);
    import dsp_pkg::*;

    logic [WEIGHT_BITS-1:0] r_mem [MAT_DEPTH];
    logic [WEIGHT_BITS-1:0] r_rd_data;
    logic                   r_clr;
    logic [MAT_BITS-1:0]    r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == MAT_BITS'(MAT_DEPTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr;

endmodule
`default_nettype wire

>>> sv/dsp_nstore.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_nstore
// Per-vertex working memory: distance, settled mark and predecessor.
// ----------------------------------------------------------------------------
module dsp_nstore (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]  i_waddr,
    input  wire dsp_pkg::t_node                i_wdata,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]  i_raddr,
    output dsp_pkg::t_node                     o_rdata
);
    import dsp_pkg::*;

    t_node r_mem [MAX_VERTICES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> sv/dense_shortest_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_shortest_path
// Dijkstra single-pair shortest path over a dense edge weight matrix.
// ----------------------------------------------------------------------------
// After reset the weight matrix is zero-filled, with i_valid not taken
// meanwhile. An edge write is a single transfer. A query sweeps the vertex
// store once to load distances, then for each settled vertex runs a scan
// sweep and a relax sweep through the registered-read weight and vertex
// memories, then walks predecessors one hop at a time and sends one result
// per cycle while the receiver is ready.
// Out-of-range vertices and unreachable destinations give a single result.
module dense_shortest_path (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [4:0]                       i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_func,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]     i_row,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]     i_col,
    input  wire logic [dsp_pkg::WEIGHT_BITS-1:0]  i_weight,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]     i_source,
    input  wire logic [dsp_pkg::VTX_BITS-1:0]     i_dest,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic      [dsp_pkg::VTX_BITS-1:0]     o_vertex,
    output logic      [dsp_pkg::COST_BITS-1:0]    o_cost,
    output logic      [1:0]                       o_status,
    output logic                                  o_last
);
    import dsp_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_INIT   = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_RELAX  = 9'b000010000,
        S_PISSUE = 9'b000100000,
        S_PTAKE  = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_ERR    = 9'b100000000
    } t_state;

    t_state                r_state;
    logic [4:0]            r_vcount;
    logic [CNT_BITS-1:0]   w_n;
    logic [VTX_BITS-1:0]   r_src, r_dst, r_bestj, r_pidx, r_v;
    logic [CNT_BITS-1:0]   r_idx, r_cnt, r_k;
    logic                  r_pv, r_found, r_dset;
    logic [COST_BITS-1:0]  r_best, r_ddist;
    logic [1:0]            r_stat;
    logic [VTX_BITS-1:0]   r_stack [MAX_VERTICES];
    logic                  r_ovalid, r_olast;
    logic [VTX_BITS-1:0]   r_ovtx;
    logic [COST_BITS-1:0]  r_ocost;
    logic [1:0]            r_ostat;

    logic                  w_busy, w_accept, w_sweep, w_issue, w_out_free, w_fin;
    logic [WEIGHT_BITS-1:0] w_wdata;
    logic [MAT_BITS-1:0]   w_wraddr;
    t_node                 w_nrd, w_nwr;
    logic                  w_nwe;
    logic [VTX_BITS-1:0]   w_nraddr, w_pred, w_top;
    logic [COST_BITS:0]    w_sum;
    logic [COST_BITS-1:0]  w_sat;

    assign w_n      = (r_vcount > 5'd16) ? CNT_BITS'(MAX_VERTICES) : CNT_BITS'(r_vcount);
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_sweep  = (r_state == S_INIT) || (r_state == S_SCAN) || (r_state == S_RELAX);
    assign w_issue  = w_sweep && (r_idx < w_n);
    assign w_out_free = !r_ovalid || i_ready;
    assign w_fin    = (r_k == r_cnt - 1'b1);
    assign w_top    = r_stack[VTX_BITS'(r_cnt - 1'b1 - r_k)];
    assign w_pred   = w_nrd.pred;

    assign w_wraddr = (r_state == S_INIT) ? {r_src, r_idx[VTX_BITS-1:0]}
                                          : {r_bestj, r_idx[VTX_BITS-1:0]};
    assign w_nraddr = (r_state == S_PISSUE) ? r_v : r_idx[VTX_BITS-1:0];

    dsp_wstore u_wstore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept && (i_func == FUNC_WRITE)),
        .i_wr_addr ({i_row, i_col}),
        .i_wr_data (i_weight),
        .i_rd_addr (w_wraddr),
        .o_rd_data (w_wdata),
        .o_busy    (w_busy)
    );

    dsp_nstore u_nstore (
        .i_clk   (i_clk),
        .i_we    (w_nwe),
        .i_waddr (r_pidx),
        .i_wdata (w_nwr),
        .i_raddr (w_nraddr),
        .o_rdata (w_nrd)
    );

    assign w_sum = {1'b0, r_best} + (COST_BITS + 1)'(w_wdata);
    assign w_sat = (w_sum > (COST_BITS + 1)'(INF_COST)) ? INF_COST : w_sum[COST_BITS-1:0];

    // Write side of the init and relax sweeps, in the cycle after each read is issued
    always_comb begin
        w_nwe = 1'b0;
        w_nwr = w_nrd;
        if (r_pv && (r_state == S_INIT)) begin
            w_nwe      = 1'b1;
            w_nwr.done = (r_pidx == r_src);
            w_nwr.pred = (w_wdata != '0) ? r_src : '0;
            if (r_pidx == r_src) begin
                w_nwr.cost = '0;
            end else if (w_wdata == '0) begin
                w_nwr.cost = INF_COST;
            end else begin
                w_nwr.cost = COST_BITS'(w_wdata);
            end
        end else if (r_pv && (r_state == S_RELAX)) begin
            if (r_pidx == r_bestj) begin
                w_nwe      = 1'b1;
                w_nwr.done = 1'b1;
            end else if (!w_nrd.done && (w_wdata != '0) && (w_sat < w_nrd.cost)) begin
                w_nwe      = 1'b1;
                w_nwr.cost = w_sat;
                w_nwr.pred = r_bestj;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 5'd16;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pv   <= w_issue;
            r_pidx <= r_idx[VTX_BITS-1:0];
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            // the emit states load the next result themselves
            if (r_ovalid && i_ready && (r_state != S_EMIT) && (r_state != S_ERR)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (!w_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && (i_func == FUNC_QUERY)) begin
                        r_src <= i_source;
                        r_dst <= i_dest;
                        r_idx <= '0;
                        if ((CNT_BITS'(i_source) >= w_n) || (CNT_BITS'(i_dest) >= w_n)) begin
                            r_stat  <= STAT_INVALID;
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (!w_issue && !r_pv) begin
                        r_idx   <= '0;
                        r_best  <= INF_COST;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        if (r_pidx == r_dst) begin
                            r_dset  <= w_nrd.done;
                            r_ddist <= w_nrd.cost;
                        end
                        if (!w_nrd.done && (w_nrd.cost < r_best)) begin
                            r_best  <= w_nrd.cost;
                            r_bestj <= r_pidx;
                            r_found <= 1'b1;
                        end
                    end else if (!w_issue) begin
                        r_idx <= '0;
                        if (r_dset) begin
                            r_v        <= r_dst;
                            r_stack[0] <= r_dst;
                            r_cnt      <= CNT_BITS'(1);
                            r_k        <= '0;
                            if ((r_dst == r_src) || (w_n <= CNT_BITS'(1))) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_PISSUE;
                            end
                        end else if (!r_found) begin
                            r_stat  <= STAT_UNREACH;
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_RELAX;
                        end
                    end
                end
                S_RELAX: begin
                    if (!w_issue && !r_pv) begin
                        r_idx   <= '0;
                        r_best  <= INF_COST;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_PISSUE: begin
                    r_state <= S_PTAKE;
                end
                S_PTAKE: begin
                    // push the predecessor, stop at the source or a full stack
                    r_stack[r_cnt[VTX_BITS-1:0]] <= w_pred;
                    r_cnt <= r_cnt + 1'b1;
                    r_v   <= w_pred;
                    if ((w_pred != r_src) && ((r_cnt + 1'b1) < w_n)) begin
                        r_state <= S_PISSUE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_ovtx   <= w_top;
                        r_ocost  <= w_fin ? r_ddist : '0;
                        r_ostat  <= STAT_OK;
                        r_olast  <= w_fin;
                        r_k      <= r_k + 1'b1;
                        if (w_fin) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_ovtx   <= '0;
                        r_ocost  <= INF_COST;
                        r_ostat  <= r_stat;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_ovalid;
    assign o_vertex = r_ovtx;
    assign o_cost   = r_ocost;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

`ifndef SYNTHESIS
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ((r_k < r_cnt) && (r_cnt != '0)))
        else $error("path emit index past stack depth");
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_last && (o_cost == INF_COST)))
        else $error("error result not single and infinite");
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> ((o_status == STAT_OK) && (o_cost == '0)))
        else $error("intermediate path result malformed");
    a_sweep_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_pv)
        else $error("sweep active during matrix clear");
`endif

endmodule
`default_nettype wire
